FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the thread-to-CPU selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  // Fixed field widths
  localparam int THREAD_W   = 16;
  localparam int CPU_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LIMIT_W    = 7;
  localparam int FULL_BITS  = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AFFINITY_MODE = 3'd0,
    REG_USER_MASK     = 3'd1,
    REG_ENV_MASK      = 3'd2,
    REG_INTERSECT_ENV = 3'd3,
    REG_CPU_LIMIT     = 3'd4
  } reg_index_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_CPU = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  // Configuration view handed to the sequencer
  typedef struct packed {
    logic [FULL_BITS-1:0] eff_mask;
    logic [LIMIT_W-1:0]   limit;
  } cfg_view_t;

endpackage

`default_nettype wire

FILE: rtl/tcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcs_cfg_regs
// Configuration registers and effective CPU mask formation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_cfg_regs
  import tcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_view_t                  view
);

  logic                  affinity_mode_r;
  logic [FULL_BITS-1:0]  user_mask_r;
  logic [FULL_BITS-1:0]  env_mask_r;
  logic                  intersect_env_r;
  logic [LIMIT_W-1:0]    cpu_limit_r;
  logic [LIMIT_W-1:0]    lim_sat;
  logic [FULL_BITS-1:0]  below;

  // Write registers on a completed transaction; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      affinity_mode_r <= 1'b0;
      user_mask_r     <= '1;
      env_mask_r      <= '1;
      intersect_env_r <= 1'b0;
      cpu_limit_r     <= LIMIT_W'(FULL_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AFFINITY_MODE: affinity_mode_r <= cfg_data[0];
        REG_USER_MASK:     user_mask_r     <= cfg_data;
        REG_ENV_MASK:      env_mask_r      <= cfg_data;
        REG_INTERSECT_ENV: intersect_env_r <= cfg_data[0];
        REG_CPU_LIMIT:     cpu_limit_r     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the limit to the full mask width
  assign lim_sat = (cpu_limit_r > LIMIT_W'(FULL_BITS)) ? LIMIT_W'(FULL_BITS) : cpu_limit_r;

  // Positions below the limit
  always_comb begin
    for (int i = 0; i < FULL_BITS; i++) begin
      below[i] = (LIMIT_W'(i) < lim_sat);
    end
  end

  // Pick user or environment mask, optionally intersect below the limit
  always_comb begin
    if (affinity_mode_r) begin
      view.eff_mask = env_mask_r;
    end else if (intersect_env_r) begin
      view.eff_mask = user_mask_r & (env_mask_r | ~below);
    end else begin
      view.eff_mask = user_mask_r;
    end
    view.limit = lim_sat;
  end

endmodule

`default_nettype wire

FILE: rtl/tcs_mod_unit.sv
// ----------------------------------------------------------------------------
// tcs_mod_unit
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_mod_unit
  import tcs_pkg::*;
#(
  parameter int DIV_W = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [THREAD_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         remainder
);

  localparam int STEP_W = $clog2(THREAD_W);

  logic                busy_r,  busy_nxt;
  logic                done_r,  done_nxt;
  logic [STEP_W-1:0]   step_r,  step_nxt;
  logic [THREAD_W-1:0] quo_r,   quo_nxt;
  logic [DIV_W-1:0]    div_r,   div_nxt;
  logic [DIV_W-1:0]    rem_r,   rem_nxt;
  logic [DIV_W:0]      trial;

  assign trial = {rem_r, quo_r[THREAD_W-1]};

  // Shift one dividend bit in, subtract when the trial value fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[THREAD_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, div_r}) ? DIV_W'(trial - {1'b0, div_r})
                                          : trial[DIV_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(THREAD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  // Remainder stays below the divisor once finished
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // Finish exactly after the last step
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without a finishing step");

  // Start never lands on a running operation from the sequencer
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("start while busy");

endmodule

`default_nettype wire

FILE: rtl/thread_to_cpu_select.sv
// ----------------------------------------------------------------------------
// thread_to_cpu_select
// Picks a CPU for a thread: nth set bit of the effective mask, modulo popcount.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a thread number. A transaction
//   is taken only while the block is idle; in_stall stays high while one
//   request is in progress.
//   Result channel (out_valid / out_stall) returns cpu_index and status; the
//   result is held in the output register until out_stall drops.
//   Configuration channel (cfg_valid / cfg_ready) writes the mode, masks and
//   CPU limit; it is always ready and must only be used while idle.
// Steps per request, with S = min(MASK_BITS, 64) and L the saturated limit:
//   population count over S mask bits (one mask bit per cycle),
//   then the remainder unit over the 16 thread bits, then done,
//   then a scan up to the hit at position k, or up to L when none is hit.
//   An empty mask skips division and scan and goes straight to the result.
// Requests: the next request is taken in the cycle after the result
//   transaction, so a request is finished before the next is accepted.
// Reset: synchronous, active low; returns to idle and loads the register
//   defaults (user and environment masks all ones, limit 64).
// ----------------------------------------------------------------------------
`default_nettype none

module thread_to_cpu_select
  import tcs_pkg::*;
#(
  parameter int MASK_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [THREAD_W-1:0]   in_thread_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CPU_W-1:0]           out_cpu_index,
  output logic [STATUS_W-1:0]        out_status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SCAN_BITS = (MASK_BITS >= FULL_BITS) ? FULL_BITS : MASK_BITS;
  localparam int CNT_W     = $clog2(SCAN_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_COUNT = 5'b00010,
    S_DIV   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                state_r,  state_nxt;
  logic [SCAN_BITS-1:0]  eff_r,    eff_nxt;
  logic [SCAN_BITS-1:0]  sh_r,     sh_nxt;
  logic [CNT_W-1:0]      pos_r,    pos_nxt;
  logic [CNT_W-1:0]      cnt_r,    cnt_nxt;
  logic [CNT_W-1:0]      seen_r,   seen_nxt;
  logic [CNT_W-1:0]      m_r,      m_nxt;
  logic [CNT_W-1:0]      lim_r,    lim_nxt;
  logic [THREAD_W-1:0]   thread_r, thread_nxt;
  logic [CPU_W-1:0]      cpu_r,    cpu_nxt;
  status_t               status_r, status_nxt;

  cfg_view_t             view;
  logic [CNT_W-1:0]      lim_cur;
  logic [CNT_W-1:0]      cnt_final;
  logic                  mod_start;
  logic                  mod_done;
  logic [CNT_W-1:0]      mod_rem;
  logic                  in_acc;

  tcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  tcs_mod_unit #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (thread_r),
    .divisor   (cnt_final),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // Limit clipped to the scanned width
  assign lim_cur   = (view.limit > LIMIT_W'(SCAN_BITS)) ? CNT_W'(SCAN_BITS)
                                                        : CNT_W'(view.limit);
  assign cnt_final = cnt_r + CNT_W'(sh_r[0]);
  assign mod_start = (state_r == S_COUNT) && (pos_r == CNT_W'(SCAN_BITS - 1))
                     && (cnt_final != '0);

  // Sequencer: count, divide, scan, deliver
  always_comb begin
    state_nxt  = state_r;
    eff_nxt    = eff_r;
    sh_nxt     = sh_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    m_nxt      = m_r;
    lim_nxt    = lim_r;
    thread_nxt = thread_r;
    cpu_nxt    = cpu_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          eff_nxt    = view.eff_mask[SCAN_BITS-1:0];
          sh_nxt     = view.eff_mask[SCAN_BITS-1:0];
          lim_nxt    = lim_cur;
          thread_nxt = in_thread_index;
          pos_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_COUNT;
        end
      end
      S_COUNT: begin
        cnt_nxt = cnt_final;
        sh_nxt  = sh_r >> 1;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == CNT_W'(SCAN_BITS - 1)) begin
          if (cnt_final == '0) begin
            cpu_nxt    = '0;
            status_nxt = ST_NO_CPU;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          m_nxt     = mod_rem;
          sh_nxt    = eff_r;
          pos_nxt   = '0;
          seen_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_r == lim_r) begin
          cpu_nxt    = '0;
          status_nxt = ST_BEYOND;
          state_nxt  = S_DONE;
        end else if (sh_r[0] && (seen_r == m_r)) begin
          cpu_nxt    = CPU_W'(pos_r);
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          seen_nxt = seen_r + CNT_W'(sh_r[0]);
          sh_nxt   = sh_r >> 1;
          pos_nxt  = pos_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    eff_r    <= eff_nxt;
    sh_r     <= sh_nxt;
    pos_r    <= pos_nxt;
    cnt_r    <= cnt_nxt;
    seen_r   <= seen_nxt;
    m_r      <= m_nxt;
    lim_r    <= lim_nxt;
    thread_r <= thread_nxt;
    cpu_r    <= cpu_nxt;
    status_r <= status_nxt;
  end

  assign out_valid     = (state_r == S_DONE);
  assign out_cpu_index = cpu_r;
  assign out_status    = status_r;

  // Failed selections report CPU zero
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (status_r != ST_OK)) |-> (cpu_r == '0))
    else $error("nonzero cpu index with error status");

  // A new request never shows a stale result next cycle
  a_no_stale_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !out_valid)
    else $error("result valid right after request");

  // Selected rank stays below the popcount
  a_rank_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (mod_rem < cnt_r))
    else $error("rank not below popcount");

  // Scan never passes the selected rank
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (seen_r <= m_r))
    else $error("scan passed selected rank");

endmodule

`default_nettype wire
